// File: rtl/ptd_pkg.sv
// Shared constants and types for the point-triangle squared distance pipeline.
// Used by ptd_mul and point_triangle_distance_sq; depends on nothing.
`default_nettype none

package ptd_pkg;

    // Result format: unsigned, 16 fraction bits, saturating at all ones
    localparam int OUT_W    = 52;
    localparam int OUT_FRAC = 16;
    localparam logic [OUT_W-1:0] SAT_VALUE = {OUT_W{1'b1}};

    // Pipelined multiplier: limb width and pipeline depth
    localparam int MUL_LIMB = 24;
    localparam int MUL_LAT  = 5;

    // Nearest region codes
    localparam logic [2:0] REGION_A  = 3'd0;
    localparam logic [2:0] REGION_B  = 3'd1;
    localparam logic [2:0] REGION_AB = 3'd2;
    localparam logic [2:0] REGION_C  = 3'd3;
    localparam logic [2:0] REGION_AC = 3'd4;
    localparam logic [2:0] REGION_BC = 3'd5;
    localparam logic [2:0] REGION_IN = 3'd6;

    // Difference vectors: B-A, C-A, P-A, P-B, P-C
    localparam int DIF_N  = 5;
    localparam int DIF_SB = 0;
    localparam int DIF_SC = 1;
    localparam int DIF_QA = 2;
    localparam int DIF_QB = 3;
    localparam int DIF_QC = 4;

    // Dot products: t1..t6, then |P-A|^2, |P-B|^2, |P-C|^2
    localparam int DOT_N   = 9;
    localparam int DOT_T1  = 0;
    localparam int DOT_T2  = 1;
    localparam int DOT_T3  = 2;
    localparam int DOT_T4  = 3;
    localparam int DOT_T5  = 4;
    localparam int DOT_T6  = 5;
    localparam int DOT_QQA = 6;
    localparam int DOT_QQB = 7;
    localparam int DOT_QQC = 8;
    localparam int DOT_L [DOT_N] = '{DIF_SB, DIF_SC, DIF_SB, DIF_SC, DIF_SB, DIF_SC,
                                     DIF_QA, DIF_QB, DIF_QC};
    localparam int DOT_R [DOT_N] = '{DIF_QA, DIF_QA, DIF_QB, DIF_QB, DIF_QC, DIF_QC,
                                     DIF_QA, DIF_QB, DIF_QC};

    // Barycentric cross products: kc = p0-p1, kb = p2-p3, ka = p4-p5
    localparam int KP_N = 6;
    localparam int KP_L [KP_N] = '{DOT_T1, DOT_T3, DOT_T5, DOT_T1, DOT_T3, DOT_T5};
    localparam int KP_R [KP_N] = '{DOT_T4, DOT_T2, DOT_T2, DOT_T6, DOT_T6, DOT_T4};
    localparam int K_A  = 0;
    localparam int K_B  = 1;
    localparam int K_C  = 2;

    // Per-item control that travels with the data
    typedef struct packed {
        logic [2:0] region;
        logic       degen;
        logic       sat;
        logic       zero;
    } tag_t;

endpackage

`default_nettype wire

// File: rtl/ptd_mul.sv
// Pipelined signed multiplier built from limb partial products.
// Depends on ptd_pkg for the limb width.
`default_nettype none

module ptd_mul #(
    parameter int AW = 52,
    parameter int BW = 52
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic signed [AW-1:0]  a,
    input  wire logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0]    p
);

    localparam int L  = ptd_pkg::MUL_LIMB;
    localparam int NA = (AW + L - 1) / L;
    localparam int NB = (BW + L - 1) / L;
    localparam int RW = (NA + 1) * L;
    localparam int SW = (NA + NB) * L;
    localparam int PW = AW + BW;

    logic [AW-1:0]   a_mag;
    logic [BW-1:0]   b_mag;
    logic [NA*L-1:0] ma_reg;
    logic [NB*L-1:0] mb_reg;
    logic [3:0]      sign_reg;
    logic [2*L-1:0]  pp_reg [NB][NA];
    logic [RW-1:0]   row_next [NB];
    logic [RW-1:0]   row_reg [NB];
    logic [SW-1:0]   sum_next;
    logic [SW-1:0]   sum_reg;
    logic [PW-1:0]   p_reg;

    // Take magnitudes
    assign a_mag = a[AW-1] ? ((~a) + AW'(1)) : a;
    assign b_mag = b[BW-1] ? ((~b) + BW'(1)) : b;

    // Fold partial products of one B limb: even and odd A limbs do not overlap
    always_comb
    begin
        logic [RW-1:0] ev;
        logic [RW-1:0] od;
        for (int j = 0; j < NB; j++)
        begin
            ev = '0;
            od = '0;
            for (int i = 0; i < NA; i++)
            begin
                if ((i % 2) == 0)
                    ev[i*L +: 2*L] = pp_reg[j][i];
                else
                    od[i*L +: 2*L] = pp_reg[j][i];
            end
            row_next[j] = ev + od;
        end
    end

    // Sum shifted rows
    always_comb
    begin
        sum_next = '0;
        for (int j = 0; j < NB; j++)
            sum_next = sum_next + (SW'(row_reg[j]) << (j * L));
    end

    // Advance the multiplier stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg   <= (NA*L)'(a_mag);
            mb_reg   <= (NB*L)'(b_mag);
            sign_reg <= {sign_reg[2:0], a[AW-1] ^ b[BW-1]};
            for (int j = 0; j < NB; j++)
                for (int i = 0; i < NA; i++)
                    pp_reg[j][i] <= ma_reg[i*L +: L] * mb_reg[j*L +: L];
            row_reg  <= row_next;
            sum_reg  <= sum_next;
            p_reg    <= sign_reg[3] ? (PW'(0) - PW'(sum_reg)) : PW'(sum_reg);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// File: rtl/point_triangle_distance_sq.sv
// Top level: squared distance from a point to a triangle, Voronoi region test.
// Depends on ptd_pkg and ptd_mul.
//
//   channel | signals                                   | handshake
//   --------+-------------------------------------------+------------------------
//   in      | point_*, corner_a_*, corner_b_*, corner_c_* | in_valid / in_ready
//   out     | distance_squared, nearest_region, degenerate | out_valid / out_ready
//
// One beat enters per cycle unless the pipeline is stalled; it passes through 70 pipeline
// stages, the first loaded at the accepting edge, then the output register. The depth
// is set by the two multiplier chains and the 52-step restoring divider, one quotient bit
// per stage. Reset clears the valid bits and the output valid only; data is not reset.
// A held output stalls the whole pipeline only when its last stage is occupied.
`default_nettype none

module point_triangle_distance_sq #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] point_x,
    input  wire logic signed [COORD_WIDTH-1:0] point_y,
    input  wire logic signed [COORD_WIDTH-1:0] point_z,
    input  wire logic signed [COORD_WIDTH-1:0] corner_a_x,
    input  wire logic signed [COORD_WIDTH-1:0] corner_a_y,
    input  wire logic signed [COORD_WIDTH-1:0] corner_a_z,
    input  wire logic signed [COORD_WIDTH-1:0] corner_b_x,
    input  wire logic signed [COORD_WIDTH-1:0] corner_b_y,
    input  wire logic signed [COORD_WIDTH-1:0] corner_b_z,
    input  wire logic signed [COORD_WIDTH-1:0] corner_c_x,
    input  wire logic signed [COORD_WIDTH-1:0] corner_c_y,
    input  wire logic signed [COORD_WIDTH-1:0] corner_c_z,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ptd_pkg::OUT_W-1:0]          distance_squared,
    output logic [2:0]                         nearest_region,
    output logic                               degenerate
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * DW;
    localparam int TW   = PW + 2;
    localparam int KW   = 2 * TW + 1;
    localparam int LW   = KW + 2;
    localparam int BW   = TW + 1;
    localparam int MW   = LW + BW;
    localparam int NW   = MW + 2;
    localparam int NU   = NW - 1;
    localparam int OW   = ptd_pkg::OUT_W;
    localparam int OF   = ptd_pkg::OUT_FRAC;
    localparam int NHW  = NU + OF - OW;
    localparam int DVW  = LW - 1 + 2 * FRAC_BITS;
    localparam int CMPW = (NHW > DVW) ? NHW : DVW;
    localparam int LAT  = ptd_pkg::MUL_LAT;

    // Valid bit positions
    localparam int V_DOT  = 2;
    localparam int V_K    = V_DOT + LAT + 1;
    localparam int V_LEN  = V_K + 1;
    localparam int V_SEL  = V_LEN + 1;
    localparam int V_NUM  = V_SEL + LAT + 1;
    localparam int V_PREP = V_NUM + 1;
    localparam int NST    = V_PREP + OW + 1;

    logic             en;
    logic [NST-1:0]   valid_reg;
    logic             out_valid_reg;

    // Stage data
    logic signed [COORD_WIDTH-1:0] pt [3];
    logic signed [COORD_WIDTH-1:0] ca [3];
    logic signed [COORD_WIDTH-1:0] cb [3];
    logic signed [COORD_WIDTH-1:0] cc [3];
    logic signed [DW-1:0] dif_reg [ptd_pkg::DIF_N][3];
    logic signed [PW-1:0] prd_reg [ptd_pkg::DOT_N][3];
    logic signed [TW-1:0] dot_reg [ptd_pkg::DOT_N];
    logic signed [TW-1:0] dot_dly_reg [LAT][ptd_pkg::DOT_N];
    logic signed [2*TW-1:0] kp [ptd_pkg::KP_N];
    logic signed [TW-1:0] dk_reg [ptd_pkg::DOT_N];
    logic signed [KW-1:0] k_reg [3];
    logic signed [TW-1:0] dl_reg [ptd_pkg::DOT_N];
    logic signed [KW-1:0] kl_reg [3];
    logic signed [TW:0]   e_reg;
    logic signed [TW:0]   f_reg;
    logic signed [TW:0]   lab_reg;
    logic signed [TW:0]   lac_reg;
    logic signed [TW+1:0] lbc_reg;
    logic signed [LW-1:0] lin_reg;

    logic [2:0]           sel_region;
    logic signed [LW-1:0] sel_len;
    logic signed [LW-1:0] sel_a [3];
    logic signed [BW-1:0] sel_b [3];
    logic                 sel_degen;

    logic signed [LW-1:0] fa_reg [3];
    logic signed [BW-1:0] fb_reg [3];
    logic signed [LW-1:0] fl_reg;
    ptd_pkg::tag_t        ft_reg;
    logic signed [MW-1:0] fp [3];
    logic signed [LW-1:0] len_dly_reg [LAT];
    ptd_pkg::tag_t        tag_dly_reg [LAT];

    logic signed [NW-1:0] num_reg;
    logic signed [LW-1:0] nlen_reg;
    ptd_pkg::tag_t        ntag_reg;

    logic [NU-1:0]        nu;
    logic [NU+OF-1:0]     nfull;
    logic [NHW-1:0]       nh;
    logic [DVW-1:0]       dv;
    logic                 num_zero;
    logic                 over;
    ptd_pkg::tag_t        ptag;

    logic [DVW-1:0]       div_r_reg [OW+1];
    logic [DVW-1:0]       div_d_reg [OW+1];
    logic [OW-1:0]        div_x_reg [OW+1];
    ptd_pkg::tag_t        div_t_reg [OW+1];
    logic [DVW:0]         trial [OW];
    logic                 ge [OW];

    logic [OW-1:0]        dist_reg;
    logic [2:0]           region_reg;
    logic                 degen_reg;

    // Pipeline moves unless the last stage is full and the output is held
    assign en       = !valid_reg[NST-1] || !out_valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        pt[0] = point_x;    pt[1] = point_y;    pt[2] = point_z;
        ca[0] = corner_a_x; ca[1] = corner_a_y; ca[2] = corner_a_z;
        cb[0] = corner_b_x; cb[1] = corner_b_y; cb[2] = corner_b_z;
        cc[0] = corner_c_x; cc[1] = corner_c_y; cc[2] = corner_c_z;
    end

    // Valid bits and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
                valid_reg <= {valid_reg[NST-2:0], in_valid};
            if (en && valid_reg[NST-1])
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Differences, dot-product terms, dot products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                dif_reg[ptd_pkg::DIF_SB][c] <= DW'(cb[c]) - DW'(ca[c]);
                dif_reg[ptd_pkg::DIF_SC][c] <= DW'(cc[c]) - DW'(ca[c]);
                dif_reg[ptd_pkg::DIF_QA][c] <= DW'(pt[c]) - DW'(ca[c]);
                dif_reg[ptd_pkg::DIF_QB][c] <= DW'(pt[c]) - DW'(cb[c]);
                dif_reg[ptd_pkg::DIF_QC][c] <= DW'(pt[c]) - DW'(cc[c]);
            end
            for (int d = 0; d < ptd_pkg::DOT_N; d++)
            begin
                for (int c = 0; c < 3; c++)
                    prd_reg[d][c] <= PW'(dif_reg[ptd_pkg::DOT_L[d]][c])
                                   * PW'(dif_reg[ptd_pkg::DOT_R[d]][c]);
                dot_reg[d] <= TW'(prd_reg[d][0]) + TW'(prd_reg[d][1]) + TW'(prd_reg[d][2]);
            end
            dot_dly_reg[0] <= dot_reg;
            for (int s = 1; s < LAT; s++)
                dot_dly_reg[s] <= dot_dly_reg[s-1];
        end
    end

    // Cross products for the barycentric terms
    for (genvar g = 0; g < ptd_pkg::KP_N; g++)
    begin : g_kmul
        ptd_mul #(.AW(TW), .BW(TW)) u_kmul (
            .clk (clk),
            .en  (en),
            .a   (dot_reg[ptd_pkg::KP_L[g]]),
            .b   (dot_reg[ptd_pkg::KP_R[g]]),
            .p   (kp[g])
        );
    end

    // Barycentric terms, then edge lengths and the interior denominator
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dk_reg            <= dot_dly_reg[LAT-1];
            k_reg[ptd_pkg::K_C] <= KW'(kp[0]) - KW'(kp[1]);
            k_reg[ptd_pkg::K_B] <= KW'(kp[2]) - KW'(kp[3]);
            k_reg[ptd_pkg::K_A] <= KW'(kp[4]) - KW'(kp[5]);

            dl_reg  <= dk_reg;
            kl_reg  <= k_reg;
            e_reg   <= (TW+1)'(dk_reg[ptd_pkg::DOT_T4]) - (TW+1)'(dk_reg[ptd_pkg::DOT_T3]);
            f_reg   <= (TW+1)'(dk_reg[ptd_pkg::DOT_T5]) - (TW+1)'(dk_reg[ptd_pkg::DOT_T6]);
            lab_reg <= (TW+1)'(dk_reg[ptd_pkg::DOT_T1]) - (TW+1)'(dk_reg[ptd_pkg::DOT_T3]);
            lac_reg <= (TW+1)'(dk_reg[ptd_pkg::DOT_T2]) - (TW+1)'(dk_reg[ptd_pkg::DOT_T6]);
            lbc_reg <= (TW+2)'(dk_reg[ptd_pkg::DOT_T4]) - (TW+2)'(dk_reg[ptd_pkg::DOT_T3])
                     + (TW+2)'(dk_reg[ptd_pkg::DOT_T5]) - (TW+2)'(dk_reg[ptd_pkg::DOT_T6]);
            lin_reg <= LW'(k_reg[ptd_pkg::K_A]) + LW'(k_reg[ptd_pkg::K_B])
                     + LW'(k_reg[ptd_pkg::K_C]);
        end
    end

    // Pick the region in test order and the operands of its distance
    always_comb
    begin
        logic signed [TW-1:0] t1, t2, t3, t6;
        t1 = dl_reg[ptd_pkg::DOT_T1];
        t2 = dl_reg[ptd_pkg::DOT_T2];
        t3 = dl_reg[ptd_pkg::DOT_T3];
        t6 = dl_reg[ptd_pkg::DOT_T6];

        if (t1 <= 0 && t2 <= 0)
            sel_region = ptd_pkg::REGION_A;
        else if (t3 >= 0 && e_reg <= 0)
            sel_region = ptd_pkg::REGION_B;
        else if (kl_reg[ptd_pkg::K_C] <= 0 && t1 >= 0 && t3 <= 0)
            sel_region = ptd_pkg::REGION_AB;
        else if (t6 >= 0 && f_reg <= 0)
            sel_region = ptd_pkg::REGION_C;
        else if (kl_reg[ptd_pkg::K_B] <= 0 && t2 >= 0 && t6 <= 0)
            sel_region = ptd_pkg::REGION_AC;
        else if (kl_reg[ptd_pkg::K_A] <= 0 && e_reg >= 0 && f_reg >= 0)
            sel_region = ptd_pkg::REGION_BC;
        else
            sel_region = ptd_pkg::REGION_IN;

        sel_len  = LW'(1);
        sel_b[0] = BW'(dl_reg[ptd_pkg::DOT_QQA]);
        for (int m = 1; m < 3; m++)
        begin
            sel_a[m] = '0;
            sel_b[m] = '0;
        end
        case (sel_region)
            ptd_pkg::REGION_A:
                sel_b[0] = BW'(dl_reg[ptd_pkg::DOT_QQA]);
            ptd_pkg::REGION_B:
                sel_b[0] = BW'(dl_reg[ptd_pkg::DOT_QQB]);
            ptd_pkg::REGION_C:
                sel_b[0] = BW'(dl_reg[ptd_pkg::DOT_QQC]);
            ptd_pkg::REGION_AB:
            begin
                sel_len  = LW'(lab_reg);
                sel_a[1] = LW'(t1);
                sel_b[1] = BW'(t1);
            end
            ptd_pkg::REGION_AC:
            begin
                sel_len  = LW'(lac_reg);
                sel_a[1] = LW'(t2);
                sel_b[1] = BW'(t2);
            end
            ptd_pkg::REGION_BC:
            begin
                sel_len  = LW'(lbc_reg);
                sel_b[0] = BW'(dl_reg[ptd_pkg::DOT_QQB]);
                sel_a[1] = LW'(e_reg);
                sel_b[1] = e_reg;
            end
            default:
            begin
                sel_len  = lin_reg;
                sel_a[1] = LW'(kl_reg[ptd_pkg::K_B]);
                sel_b[1] = BW'(t1);
                sel_a[2] = LW'(kl_reg[ptd_pkg::K_C]);
                sel_b[2] = BW'(t2);
            end
        endcase
        sel_a[0]  = sel_len;
        sel_degen = (sel_len <= 0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fa_reg        <= sel_a;
            fb_reg        <= sel_b;
            fl_reg        <= sel_len;
            ft_reg.region <= sel_region;
            ft_reg.degen  <= sel_degen;
            ft_reg.sat    <= 1'b0;
            ft_reg.zero   <= 1'b0;
            len_dly_reg[0] <= fl_reg;
            tag_dly_reg[0] <= ft_reg;
            for (int s = 1; s < LAT; s++)
            begin
                len_dly_reg[s] <= len_dly_reg[s-1];
                tag_dly_reg[s] <= tag_dly_reg[s-1];
            end
        end
    end

    // Numerator products: len*|q|^2 and the two correction terms
    for (genvar g = 0; g < 3; g++)
    begin : g_fmul
        ptd_mul #(.AW(LW), .BW(BW)) u_fmul (
            .clk (clk),
            .en  (en),
            .a   (fa_reg[g]),
            .b   (fb_reg[g]),
            .p   (fp[g])
        );
    end

    // Scale numerator and denominator, test for zero and for overflow
    always_comb
    begin
        nu       = num_reg[NU-1:0];
        nfull    = {nu, {OF{1'b0}}};
        nh       = nfull[NU+OF-1:OW];
        dv       = DVW'(nlen_reg[LW-2:0]) << (2 * FRAC_BITS);
        num_zero = (num_reg <= 0);
        over     = CMPW'(nh) >= CMPW'(dv);
        ptag        = ntag_reg;
        ptag.sat    = ntag_reg.degen || (!num_zero && over);
        ptag.zero   = !ntag_reg.degen && num_zero;
    end

    // One quotient bit per stage
    always_comb
    begin
        for (int k = 0; k < OW; k++)
        begin
            trial[k] = {div_r_reg[k], div_x_reg[k][OW-1]};
            ge[k]    = trial[k] >= {1'b0, div_d_reg[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= NW'(fp[0]) - NW'(fp[1]) - NW'(fp[2]);
            nlen_reg <= len_dly_reg[LAT-1];
            ntag_reg <= tag_dly_reg[LAT-1];

            div_r_reg[0] <= DVW'(nh);
            div_d_reg[0] <= dv;
            div_x_reg[0] <= nfull[OW-1:0];
            div_t_reg[0] <= ptag;
            for (int k = 0; k < OW; k++)
            begin
                div_r_reg[k+1] <= ge[k] ? DVW'(trial[k] - {1'b0, div_d_reg[k]})
                                        : DVW'(trial[k]);
                div_d_reg[k+1] <= div_d_reg[k];
                div_x_reg[k+1] <= {div_x_reg[k][OW-2:0], ge[k]};
                div_t_reg[k+1] <= div_t_reg[k];
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en && valid_reg[NST-1])
        begin
            if (div_t_reg[OW].sat)
                dist_reg <= ptd_pkg::SAT_VALUE;
            else if (div_t_reg[OW].zero)
                dist_reg <= '0;
            else
                dist_reg <= div_x_reg[OW];
            region_reg <= div_t_reg[OW].region;
            degen_reg  <= div_t_reg[OW].degen;
        end
    end

    assign out_valid        = out_valid_reg;
    assign distance_squared = dist_reg;
    assign nearest_region   = region_reg;
    assign degenerate       = degen_reg;

    // A degenerate result always carries the saturated distance
    a_degen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> distance_squared == ptd_pkg::SAT_VALUE)
        else $error("degenerate result without saturated distance");

    // Vertex regions never divide, so they are never degenerate
    a_degen_region: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> nearest_region != ptd_pkg::REGION_A
            && nearest_region != ptd_pkg::REGION_B && nearest_region != ptd_pkg::REGION_C)
        else $error("degenerate flag on a vertex region");

    // Input is refused only when the last stage and the output are both full
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> valid_reg[NST-1] && out_valid_reg)
        else $error("input stalled with room in the pipeline");

    // A stall freezes every valid bit
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("valid bits moved during a stall");

endmodule

`default_nettype wire
